/* hdl/srhpe_pkg.sv */
// Shared types, constants and helpers for the slope-run half-period estimator.
package srhpe_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RUN_W    = 5;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IDX_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_THRESHOLD   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGREE_TOLERANCE = 4'd1;

  localparam logic [CFG_W-1:0] RUN_THRESHOLD_RST   = 4'd3;
  localparam logic [CFG_W-1:0] AGREE_TOLERANCE_RST = 4'd1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } srhpe_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic step;       // take one sample into the run tracker
    logic scan_init;  // restart the slot scan
    logic scan_step;  // visit one slot
    logic div_init;   // load the divider
    logic div_step;   // one quotient bit
    logic load_out;   // capture the result
    logic clear;      // drop capture state
  } srhpe_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_end;
    logic div_end;
  } srhpe_sts_t;

  // Saturating 5-bit increment
  function automatic logic [RUN_W-1:0] sat_inc5(input logic [RUN_W-1:0] v);
    logic [RUN_W-1:0] res;
    res = (v == {RUN_W{1'b1}}) ? v : v + 1'b1;
    return res;
  endfunction

endpackage

/* hdl/srhpe_dp.sv */
// Datapath: run tracking, slot ring, slot scan, restoring divider, result register.
module srhpe_dp #(
  parameter int unsigned SLOT_COUNT = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srhpe_pkg::srhpe_cmd_t         cmd,
  output srhpe_pkg::srhpe_sts_t         sts,
  input  logic [srhpe_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          cfg_we,
  input  logic [srhpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srhpe_pkg::CFG_W-1:0]   cfg_data,
  output logic [srhpe_pkg::SAMPLE_W-1:0] half_period,
  output logic                          found
);
  import srhpe_pkg::*;

  localparam int unsigned PTR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SUM_W = SAMPLE_W + CNT_W;
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOT_COUNT - 1);

  // Configuration registers
  logic [CFG_W-1:0] run_thr_r;
  logic [CFG_W-1:0] agree_tol_r;

  // Capture state
  logic [SAMPLE_W-1:0] prev_sample_r, prev_sample_nxt;
  logic [SAMPLE_W-1:0] sample_idx_r, sample_idx_nxt;
  logic [RUN_W-1:0]    rise_cnt_r, rise_cnt_nxt;
  logic [RUN_W-1:0]    fall_cnt_r, fall_cnt_nxt;
  logic [SAMPLE_W-1:0] peak_idx_r, peak_idx_nxt;
  logic [PTR_W-1:0]    slot_ptr_r, slot_ptr_nxt;
  logic [SAMPLE_W-1:0] slot_data_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_vld_r;
  logic                slot_we;
  logic [SAMPLE_W-1:0] slot_dist;
  logic                is_up, is_down;

  // Scan and divider state
  logic [PTR_W-1:0]    scan_j_r;
  logic [SAMPLE_W-1:0] scan_prev_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SAMPLE_W-1:0] scan_rd;
  logic [SAMPLE_W-1:0] scan_diff;
  logic                scan_qual;
  logic [SUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic [DCNT_W-1:0]   div_cnt_r;
  logic [CNT_W:0]      trial;
  logic                trial_ge;
  logic [CNT_W:0]      trial_sub;

  logic [SAMPLE_W-1:0] half_r;
  logic                found_r;

  // Hold configuration; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_thr_r   <= RUN_THRESHOLD_RST;
      agree_tol_r <= AGREE_TOLERANCE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RUN_THRESHOLD)   run_thr_r   <= cfg_data;
      if (cfg_index == CFG_AGREE_TOLERANCE) agree_tol_r <= cfg_data;
    end
  end

  // Track rise and fall runs, mark peaks and troughs
  always_comb begin
    is_up           = in_sample > prev_sample_r;
    is_down         = in_sample < prev_sample_r;
    rise_cnt_nxt    = rise_cnt_r;
    fall_cnt_nxt    = fall_cnt_r;
    peak_idx_nxt    = peak_idx_r;
    slot_ptr_nxt    = slot_ptr_r;
    slot_we         = 1'b0;
    slot_dist       = sample_idx_r - 16'd1 - peak_idx_r;
    prev_sample_nxt = in_sample;
    if (sample_idx_r != '0) begin
      if (is_up) rise_cnt_nxt = sat_inc5(rise_cnt_r);
      if (is_down && (rise_cnt_r > {1'b0, run_thr_r})) begin
        rise_cnt_nxt = '0;
        peak_idx_nxt = sample_idx_r - 16'd1;
      end
      if (is_down) fall_cnt_nxt = sat_inc5(fall_cnt_r);
      if (is_up && (fall_cnt_r > {1'b0, run_thr_r})) begin
        fall_cnt_nxt = '0;
        slot_we      = 1'b1;
        slot_ptr_nxt = (slot_ptr_r == PTR_LAST) ? '0 : slot_ptr_r + 1'b1;
      end
    end
    sample_idx_nxt = (sample_idx_r == {SAMPLE_W{1'b1}}) ? sample_idx_r
                                                          : sample_idx_r + 1'b1;
  end

  // Advance capture state; clear drops it between captures
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      prev_sample_r <= '0;
      sample_idx_r  <= '0;
      rise_cnt_r    <= '0;
      fall_cnt_r    <= '0;
      peak_idx_r    <= '0;
      slot_ptr_r    <= '0;
      slot_vld_r    <= '0;
    end else if (cmd.step) begin
      prev_sample_r <= prev_sample_nxt;
      sample_idx_r  <= sample_idx_nxt;
      rise_cnt_r    <= rise_cnt_nxt;
      fall_cnt_r    <= fall_cnt_nxt;
      peak_idx_r    <= peak_idx_nxt;
      slot_ptr_r    <= slot_ptr_nxt;
      if (slot_we) slot_vld_r[slot_ptr_r] <= 1'b1;
    end
  end

  // Slot ring payload
  always_ff @(posedge clk) begin
    if (cmd.step && slot_we) slot_data_r[slot_ptr_r] <= slot_dist;
  end

  // Qualify one slot against the one before it
  always_comb begin
    scan_rd   = slot_vld_r[scan_j_r] ? slot_data_r[scan_j_r] : '0;
    scan_diff = (scan_rd > scan_prev_r) ? scan_rd - scan_prev_r : scan_prev_r - scan_rd;
    scan_qual = (scan_j_r != '0) && (scan_diff <= {{(SAMPLE_W-CFG_W){1'b0}}, agree_tol_r})
                && (scan_rd != '0);
  end

  // Accumulate qualifying slots
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_init) begin
      scan_j_r    <= '0;
      scan_prev_r <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else if (cmd.scan_step) begin
      scan_j_r    <= scan_j_r + 1'b1;
      scan_prev_r <= scan_rd;
      if (scan_qual) begin
        sum_r <= sum_r + {{CNT_W{1'b0}}, scan_rd};
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // One quotient bit per cycle, restoring
  always_comb begin
    trial     = {rem_r, quo_r[SUM_W-1]};
    trial_ge  = trial >= {1'b0, cnt_r};
    trial_sub = trial - {1'b0, cnt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_init) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r <= sum_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], trial_ge};
      rem_r <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found_r <= (cnt_r != '0);
      half_r  <= (cnt_r != '0) ? quo_r[SAMPLE_W-1:0] : '0;
    end
  end

  assign sts.scan_end = (scan_j_r == PTR_LAST);
  assign sts.div_end  = (div_cnt_r == DCNT_W'(SUM_W - 1));
  assign half_period  = half_r;
  assign found        = found_r;

  // Qualifying count never exceeds the neighbor pairs
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOT_COUNT - 1))
    else $error("qualifying slot count out of range");

  // Ring pointer stays inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_ptr_r <= PTR_LAST)
    else $error("slot pointer out of range");

  // Clear leaves an empty capture behind
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (sample_idx_r == '0) && (slot_vld_r == '0) && (slot_ptr_r == '0))
    else $error("capture state not cleared");

endmodule

/* hdl/srhpe_ctrl.sv */
// Controller: sequences sample intake, slot scan, division and result handoff.
module srhpe_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output srhpe_pkg::srhpe_cmd_t cmd,
  input  srhpe_pkg::srhpe_sts_t sts
);
  import srhpe_pkg::*;

  srhpe_state_t state_r, state_nxt;
  logic         out_vld_r, out_vld_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    out_vld_nxt = (out_vld_r && out_tready) ? 1'b0 : out_vld_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.step = 1'b1;
          if (in_tlast) begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_end) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait until the output register is free
        if (!out_vld_r || out_tready) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          out_vld_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_vld_r;

endmodule

/* hdl/slope_run_half_period_estimator.sv */
// Top level: slope-run half-period estimator with stream ports and a config write port.
// Samples are taken one per cycle while the block is idle; a sample without the last flag yields no result.
// After the last sample, the slots are scanned one per cycle, then a restoring divider runs one bit
// per cycle; the result is loaded into the output register once that register is free.
// Input is held off from the last transfer until the result is loaded into the output register.
// Synchronous active-low reset clears capture state and loads thresholds 3 and tolerance 1.
module slope_run_half_period_estimator #(
  parameter int unsigned SLOT_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] half_period
  output logic        out_tuser,  // [0] found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [srhpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srhpe_pkg::CFG_W-1:0]     cfg_data
);
  import srhpe_pkg::*;

  srhpe_cmd_t cmd;
  srhpe_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequence the work
  srhpe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Do the arithmetic
  srhpe_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_sample   (in_tdata),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .half_period (out_tdata),
    .found       (out_tuser)
  );

endmodule

/* verif/slope_run_half_period_estimator_test.sv */
// Self-checking testbench for the slope-run half-period estimator.
`timescale 1ns / 1ps

import srhpe_pkg::*;

typedef struct packed {
  logic [15:0] half_period;
  logic        found;
} estimate_t;

// Tracks the block's capture state and holds the estimates still owed.
class half_period_scoreboard #(int unsigned SLOTS = 10);
  logic [CFG_W-1:0] run_threshold;
  logic [CFG_W-1:0] agree_tolerance;
  logic [15:0]      prev_sample;
  logic [15:0]      sample_pos;
  logic [15:0]      peak_pos;
  logic [4:0]       rise_run;
  logic [4:0]       fall_run;
  int unsigned      slot_ptr;
  logic [15:0]      slot_ring [SLOTS];
  int unsigned      capture_len;
  estimate_t        expected_estimates [$];
  int unsigned      mismatches;
  int unsigned      samples_in;
  int unsigned      captures;
  int unsigned      found_count;
  int unsigned      results_seen;
  int unsigned      longest_capture;

  function new();
    run_threshold   = RUN_THRESHOLD_RST;
    agree_tolerance = AGREE_TOLERANCE_RST;
    mismatches      = 0;
    samples_in      = 0;
    captures        = 0;
    found_count     = 0;
    results_seen    = 0;
    longest_capture = 0;
    clear_capture();
  endfunction

  function void clear_capture();
    prev_sample = '0;
    sample_pos  = '0;
    peak_pos    = '0;
    rise_run    = '0;
    fall_run    = '0;
    slot_ptr    = 0;
    capture_len = 0;
    foreach (slot_ring[j]) slot_ring[j] = '0;
  endfunction

  // Unknown indexes are dropped by the block
  function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
    case (index)
      CFG_RUN_THRESHOLD:   run_threshold = value;
      CFG_AGREE_TOLERANCE: agree_tolerance = value;
      default: ;
    endcase
  endfunction

  // Advance the run tracker by one accepted sample
  function void note_sample(logic [15:0] cur, logic last);
    logic        up;
    logic        down;
    int unsigned sum;
    int unsigned n;
    int unsigned a;
    int unsigned b;
    int unsigned d;
    estimate_t   est;
    samples_in++;
    capture_len++;
    if (sample_pos != 16'd0) begin
      up   = cur > prev_sample;
      down = cur < prev_sample;
      if (up && rise_run != 5'd31) rise_run++;
      // A fall after a long enough rise marks the previous sample as a peak
      if (down && rise_run > run_threshold) begin
        rise_run = '0;
        peak_pos = sample_pos - 16'd1;
      end
      if (down && fall_run != 5'd31) fall_run++;
      // A rise after a long enough fall is a trough: store its distance
      if (up && fall_run > run_threshold) begin
        fall_run = '0;
        slot_ring[slot_ptr] = sample_pos - 16'd1 - peak_pos;
        slot_ptr = (slot_ptr + 1) % SLOTS;
      end
    end
    prev_sample = cur;
    if (sample_pos != 16'hFFFF) sample_pos++;
    if (!last) return;

    // Average the slots that agree with their left neighbor
    sum = 0;
    n   = 0;
    for (int j = 1; j < SLOTS; j++) begin
      a = slot_ring[j-1];
      b = slot_ring[j];
      d = (a > b) ? a - b : b - a;
      if (d <= agree_tolerance && b != 0) begin
        sum += b;
        n++;
      end
    end
    est.found       = (n != 0);
    est.half_period = (n != 0) ? 16'(sum / n) : 16'd0;
    expected_estimates.push_back(est);
    captures++;
    if (est.found) found_count++;
    if (capture_len > longest_capture) longest_capture = capture_len;
    clear_capture();
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, what);
    mismatches++;
  endtask

  task check_estimate(logic [15:0] half_period, logic found);
    estimate_t want;
    if (expected_estimates.size() == 0) begin
      report_mismatch($sformatf("half_period %0d found %0b with nothing expected",
                                half_period, found));
      return;
    end
    want = expected_estimates.pop_front();
    if (half_period !== want.half_period)
      report_mismatch($sformatf("half_period %0d, expected %0d", half_period,
                                want.half_period));
    if (found !== want.found)
      report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
    results_seen++;
  endtask
endclass

module slope_run_half_period_estimator_test;
  localparam int unsigned SLOT_COUNT   = 10;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  half_period_scoreboard #(SLOT_COUNT) sb;
  bit          calm;
  bit          start_hold_off;
  int unsigned sender_idle_pct;
  int unsigned settings_used;

  slope_run_half_period_estimator #(.SLOT_COUNT(SLOT_COUNT)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned gap_left;
    hold_left  = 0;
    gap_left   = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (start_hold_off) begin
        start_hold_off = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        gap_left = $urandom_range(0, 7);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_estimate(out_tdata, out_tuser);
  end

  initial begin
    #20_000_000;
    $display("Timeout: the run did not complete");
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one sample and hold it until the transfer
  task automatic send_sample(input logic [15:0] value, input logic last);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(value, last);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every owed estimate, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_estimates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] tol);
    wait_drained();
    write_reg(CFG_RUN_THRESHOLD, thr);
    write_reg(CFG_AGREE_TOLERANCE, tol);
    write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_W'($urandom));
    settings_used++;
  endtask

  // Triangle wave capture: segments of about half samples, with optional jitter and noise
  task automatic send_wave(input int half, input int jitter, input int len,
                           input int max_step, input int noise_pct);
    int          level;
    int          dir;
    int          seg_left;
    logic [15:0] value;
    level    = $urandom_range(0, 65535);
    dir      = $urandom_range(0, 1) ? 1 : -1;
    seg_left = half;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) value = 16'($urandom);
      else value = 16'(level);
      send_sample(value, i == len - 1);
      level = level + dir * $urandom_range(1, max_step);
      if (level > 65535) level = 65535;
      if (level < 0) level = 0;
      seg_left = seg_left - 1;
      if (seg_left <= 0) begin
        dir = -dir;
        seg_left = half - jitter + $urandom_range(0, 2 * jitter);
        if (seg_left < 1) seg_left = 1;
      end
    end
  endtask

  // Mostly clean periodic captures, some jittered, some pure noise or off-period
  task automatic run_capture();
    int pick;
    int half;
    int step;
    pick = $urandom_range(0, 99);
    half = int'(sb.run_threshold) + 1 + $urandom_range(0, 3);
    case ($urandom_range(0, 2))
      0:       step = 1;
      1:       step = 300;
      default: step = 5000;
    endcase
    sender_idle_pct = calm ? 0 : ($urandom_range(0, 1) ? 25 : 0);
    if (pick < 60)
      send_wave(half, 0, 2 * half * $urandom_range(2, 7) + $urandom_range(0, 3), step, 0);
    else if (pick < 80)
      send_wave(half, $urandom_range(1, 3), 2 * half * $urandom_range(1, 6), step, 5);
    else if (pick < 90)
      send_wave(1, 0, $urandom_range(1, 30), 65535, 100);
    else
      send_wave($urandom_range(1, int'(sb.run_threshold) + 3), 0, $urandom_range(1, 60),
                step, 0);
  endtask

  task automatic run_captures(input int unsigned items);
    int unsigned first;
    first = sb.samples_in;
    while (sb.samples_in - first < items) run_capture();
  endtask

  initial begin
    sb              = new();
    calm            = 1'b0;
    start_hold_off  = 1'b0;
    sender_idle_pct = 25;
    settings_used   = 1;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tlast        = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, at reset settings: single-sample capture at full scale
    send_sample(16'hFFFF, 1'b1);
    // Extremes with a flat step in between
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    // One peak then one trough: a single slot, nothing agrees
    for (int i = 0; i <= 4; i++) send_sample(16'(i), 1'b0);
    for (int i = 3; i >= 0; i--) send_sample(16'(i), 1'b0);
    send_sample(16'd1, 1'b1);
    // Trough with no peak seen yet, distance from position zero
    for (int i = 5; i >= 1; i--) send_sample(16'(i), 1'b0);
    send_sample(16'd2, 1'b1);

    // Corner settings; the first one also stalls the receiver for a long stretch
    configure(4'd0, 4'd0);
    start_hold_off = 1'b1;
    run_captures(200);
    configure(4'd15, 4'd15);
    run_captures(250);
    configure(4'd15, 4'd0);
    run_captures(200);
    configure(4'd0, 4'd15);
    run_captures(150);
    configure(RUN_THRESHOLD_RST, AGREE_TOLERANCE_RST);
    run_captures(150);

    // Random settings until enough samples and estimates have gone through
    while (sb.samples_in < 1200 || sb.captures < 48) begin
      configure(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 15)));
      run_captures(150);
    end

    // Final stretch without idling: ends in one long clean capture
    calm = 1'b1;
    configure(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 3)));
    run_captures(100);
    send_wave(int'(sb.run_threshold) + 3, 0, 200, 2, 0);
    wait_drained();

    $display("Run covered %0d captures (%0d with an agreeing estimate), %0d samples, %0d settings.",
             sb.captures, sb.found_count, sb.samples_in, settings_used);
    $display("Longest capture was %0d samples; a long output stall and drained pauses were included.",
             sb.longest_capture);
    if (sb.mismatches == 0 && sb.expected_estimates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
